### sv/pll_divider_multiplier_search_macros.svh
// Assertion macros for the PLL divider and multiplier search block.
`ifndef PLL_DIVIDER_MULTIPLIER_SEARCH_MACROS_SVH
`define PLL_DIVIDER_MULTIPLIER_SEARCH_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PDMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PDMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pdms_pkg.sv
// Package with types and constants of the PLL divider and multiplier search.
package pdms_pkg;

    localparam int TgtW  = 26;  // target / 10
    localparam int SrcW  = 24;  // source / 10, also the divisor width
    localparam int VinW  = 18;  // PLL input frequency after range check
    localparam int MulW  = 9;
    localparam int DivW  = 6;
    localparam int QW    = 32;  // dividend and quotient width
    localparam int CandW = VinW + MulW;
    localparam int CntW  = 6;   // holds QW itself

    localparam logic [DivW-1:0] DivFirst = 6'd2;
    localparam logic [DivW-1:0] DivLast  = 6'd63;
    localparam logic [MulW-1:0] MulMin   = 9'd192;
    localparam logic [MulW-1:0] MulMax   = 9'd432;
    localparam logic [VinW-1:0] VinMin   = 18'(1 * 1000 * 1000 / 10);
    localparam logic [VinW-1:0] VinMax   = 18'(2 * 1000 * 1000 / 10);
    localparam logic [SrcW-1:0] Scale    = 24'd10;
    localparam logic [CntW-1:0] DivSteps = 6'(QW);

    typedef struct packed {
        logic            start;
        logic [QW-1:0]   dividend;
        logic [SrcW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_WT   = 9'b000000010,
        S_WS   = 9'b000000100,
        S_WVIN = 9'b000001000,
        S_WM   = 9'b000010000,
        S_CAND = 9'b000100000,
        S_CMP  = 9'b001000000,
        S_ADV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

endpackage

### sv/pdms_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module pdms_divider
    import pdms_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [SrcW-1:0] rem_reg, rem_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [SrcW-1:0] dsr_reg, dsr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [SrcW:0] trial;
    logic [SrcW:0] diff;
    logic          fits;

    assign trial = {rem_reg, quo_reg[QW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = DivSteps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when the divisor fits
            rem_next = fits ? diff[SrcW-1:0] : trial[SrcW-1:0];
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/pll_divider_multiplier_search.sv
// Top level: PLL input divider and multiplier search around a shared divider.
// Flow: two divisions scale the inputs; each divider 2..63 then costs a division for its
// PLL input, another when that input is in range, and a candidate and compare step when
// its multiplier is in range too.
// Throughput: one item at a time; the next item is taken after the result is taken.
// Reset: rst_n clears the sequencer and the divider control; no result is pending.
module pll_divider_multiplier_search
    import pdms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // target_hz[28:0], source_hz[55:29]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // divider[5:0], multiplier[14:6], zero[15]
    output logic        m_axis_tuser   // found[0]
);

    `include "pll_divider_multiplier_search_macros.svh"

    state_t state_reg, state_next;

    // search operands and running best candidate
    logic [26:0]      src_raw_reg, src_raw_next;
    logic [TgtW-1:0]  target_reg, target_next;
    logic [SrcW-1:0]  source_reg, source_next;
    logic [DivW-1:0]  d_reg, d_next;
    logic [VinW-1:0]  vin_reg, vin_next;
    logic [MulW-1:0]  mul_reg, mul_next;
    logic [CandW-1:0] cand_reg, cand_next;
    logic [CandW-1:0] best_err_reg, best_err_next;
    logic [DivW-1:0]  best_div_reg, best_div_next;
    logic [MulW-1:0]  best_mul_reg, best_mul_next;
    logic             have_reg, have_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [QW-1:0]    q;
    logic [QW-1:0]    prod;
    logic [CandW-1:0] tgt_ext;
    logic [CandW-1:0] err;
    logic [DivW-1:0]  d_inc;

    pdms_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q       = div_rsp.quotient;
    // at most 32 bits for 29-bit targets
    assign prod    = {{(QW-TgtW){1'b0}}, target_reg} * {{(QW-DivW){1'b0}}, d_reg};
    assign tgt_ext = {1'b0, target_reg};
    assign err     = (tgt_ext >= cand_reg) ? (tgt_ext - cand_reg) : (cand_reg - tgt_ext);
    assign d_inc   = d_reg + 1'b1;

    // Sequencer: every division goes through the shared divider.
    always_comb
    begin
        state_next    = state_reg;
        src_raw_next  = src_raw_reg;
        target_next   = target_reg;
        source_next   = source_reg;
        d_next        = d_reg;
        vin_next      = vin_reg;
        mul_next      = mul_reg;
        cand_next     = cand_reg;
        best_err_next = best_err_reg;
        best_div_next = best_div_reg;
        best_mul_next = best_mul_reg;
        have_next     = have_reg;
        div_req       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    // scale the target first, hold the source for later
                    src_raw_next     = s_axis_tdata[55:29];
                    div_req.start    = 1'b1;
                    div_req.dividend = {3'b0, s_axis_tdata[28:0]};
                    div_req.divisor  = Scale;
                    state_next       = S_WT;
                end
            end
            S_WT:
            begin
                if (div_rsp.done)
                begin
                    target_next      = q[TgtW-1:0];
                    best_err_next    = {1'b0, q[TgtW-1:0]};
                    best_div_next    = DivLast;
                    best_mul_next    = MulMin;
                    have_next        = 1'b0;
                    div_req.start    = 1'b1;
                    div_req.dividend = {5'b0, src_raw_reg};
                    div_req.divisor  = Scale;
                    state_next       = S_WS;
                end
            end
            S_WS:
            begin
                if (div_rsp.done)
                begin
                    source_next      = q[SrcW-1:0];
                    d_next           = DivFirst;
                    div_req.start    = 1'b1;
                    div_req.dividend = {8'b0, q[SrcW-1:0]};
                    div_req.divisor  = {18'b0, DivFirst};
                    state_next       = S_WVIN;
                end
            end
            S_WVIN:
            begin
                if (div_rsp.done)
                begin
                    // drop the divider when the PLL input leaves its range
                    if (q >= {14'b0, VinMin} && q <= {14'b0, VinMax})
                    begin
                        vin_next         = q[VinW-1:0];
                        div_req.start    = 1'b1;
                        div_req.dividend = prod;
                        div_req.divisor  = source_reg;
                        state_next       = S_WM;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_WM:
            begin
                if (div_rsp.done)
                begin
                    if (q >= {23'b0, MulMin} && q <= {23'b0, MulMax})
                    begin
                        mul_next   = q[MulW-1:0];
                        state_next = S_CAND;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_CAND:
            begin
                cand_next  = {{(CandW-VinW){1'b0}}, vin_reg} * {{(CandW-MulW){1'b0}}, mul_reg};
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // strictly better only: an equal error keeps the earlier divider
                if (err < best_err_reg)
                begin
                    best_err_next = err;
                    best_div_next = d_reg;
                    best_mul_next = mul_reg;
                    have_next     = 1'b1;
                    state_next    = (err == '0) ? S_OUT : S_ADV;
                end
                else
                begin
                    state_next = S_ADV;
                end
            end
            S_ADV:
            begin
                if (d_reg == DivLast)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    d_next           = d_inc;
                    div_req.start    = 1'b1;
                    div_req.dividend = {8'b0, source_reg};
                    div_req.divisor  = {18'b0, d_inc};
                    state_next       = S_WVIN;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_raw_reg  <= src_raw_next;
        target_reg   <= target_next;
        source_reg   <= source_next;
        d_reg        <= d_next;
        vin_reg      <= vin_next;
        mul_reg      <= mul_next;
        cand_reg     <= cand_next;
        best_err_reg <= best_err_next;
        best_div_reg <= best_div_next;
        best_mul_reg <= best_mul_next;
        have_reg     <= have_next;
    end

    // The best registers start at the not-found answer, so they drive the item as is.
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {1'b0, best_mul_reg, best_div_reg};
    assign m_axis_tuser  = have_reg;

    `PDMS_ASSERT(a_found_in_range,
        (m_axis_tvalid && m_axis_tuser) |->
            (best_mul_reg >= MulMin && best_mul_reg <= MulMax && best_div_reg >= DivFirst),
        "found result carries an out-of-range setting")
    `PDMS_ASSERT(a_busy_not_ready,
        (div_rsp.busy || m_axis_tvalid) |-> !s_axis_tready,
        "input ready while a search or a result is pending")
    `PDMS_ASSERT(a_start_when_free,
        div_req.start |-> (!div_rsp.busy && (div_rsp.done || s_axis_tready || state_reg == S_ADV)),
        "divider started while still working")
    `PDMS_ASSERT_ALWAYS(a_reset_quiet,
        !rst_n |=> !m_axis_tvalid,
        "result valid during reset")

endmodule
